// File: design/rbpq_pkg.sv
// package for the ready/blocked process queues
// shared widths, command and status codes and the command queue entry type
// no dependencies
package rbpq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;

  localparam int CMD_W   = 3;
  localparam int PID_W   = 16;
  localparam int PAGES_W = 20;
  localparam int ENTRY_W = PID_W + PAGES_W;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP     = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [PID_W-1:0]   pid;
    logic [PAGES_W-1:0] pages;
  } cmd_t;

endpackage

// File: design/rbpq_front.sv
// front end: takes input transfers, decodes the command and holds them in a
// two-entry queue for the back end; depends on rbpq_pkg
module rbpq_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,   // pid, page_count
  input  logic [2:0]            s_tuser,   // command
  output logic                  q_valid,
  output rbpq_pkg::cmd_t        q_cmd,
  input  logic                  q_pop
);
  import rbpq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.pid   = s_tdata[PID_W-1:0];
    dec.pages = s_tdata[PID_W+PAGES_W-1:PID_W];
    unique case (s_tuser)
      CMD_LOAD, CMD_BLOCK, CMD_UNBLOCK, CMD_REMOVE, CMD_PEEK, CMD_SEARCH: dec.op = s_tuser;
      default: dec.op = CMD_NOP;
    endcase
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: design/rbpq_back.sv
// back end: both queue memories, head/tail/fill registers, the command
// sequencer and the result register; depends on rbpq_pkg
module rbpq_back #(
  parameter int QUEUE_DEPTH = rbpq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  rbpq_pkg::cmd_t        q_cmd,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // out_pid, out_pages, ready_count, blocked_count
  output logic [2:0]            m_tuser    // status, found_blocked
);
  import rbpq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DATA = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_CMP  = 2'd3;

  logic [ENTRY_W-1:0] ready_mem   [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] blocked_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] r_rd_data;
  logic [ENTRY_W-1:0] b_rd_data;
  logic [PTR_W-1:0]   r_addr;
  logic [PTR_W-1:0]   b_addr;

  logic [1:0]       state;
  cmd_t             cur;
  logic [PTR_W-1:0] r_head, r_tail, b_head, b_tail, ptr;
  logic [CNT_W-1:0] r_fill, b_fill, n;
  logic             phase;

  logic [STAT_W-1:0]  o_status;
  logic [PID_W-1:0]   o_pid;
  logic [PAGES_W-1:0] o_pages;
  logic               o_found;
  logic [CNT_W-1:0]   o_rc, o_bc;

  logic               r_we, b_we;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] cmp_data;
  logic [CNT_W-1:0]   lim;
  logic               idle_done;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + 1'b1;
    return (s == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : s[PTR_W-1:0];
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid && (!m_tvalid || m_tready);
  assign r_addr = (state == S_SRCH && !phase) ? ptr : r_head;
  assign b_addr = (state == S_SRCH && phase) ? ptr : b_head;
  assign cmp_data = phase ? b_rd_data : r_rd_data;
  assign lim = phase ? b_fill : r_fill;

  assign m_tdata = {6'd0, OCNT_W'(o_bc), OCNT_W'(o_rc), o_pages, o_pid};
  assign m_tuser = {o_found, o_status};

  // command finishes in the cycle it is taken
  always_comb begin
    unique case (q_cmd.op) inside
      CMD_BLOCK:            idle_done = (r_fill == '0) || (b_fill == FULL_CNT);
      CMD_UNBLOCK:          idle_done = (b_fill == '0) || (r_fill == FULL_CNT);
      CMD_REMOVE, CMD_PEEK: idle_done = (r_fill == '0);
      CMD_SEARCH:           idle_done = 1'b0;
      default:              idle_done = 1'b1;
    endcase
  end

  always_comb begin
    r_we     = 1'b0;
    b_we     = 1'b0;
    wr_entry = r_rd_data;
    if (state == S_IDLE && q_pop && q_cmd.op == CMD_LOAD && r_fill != FULL_CNT) begin
      r_we     = 1'b1;
      wr_entry = {q_cmd.pid, q_cmd.pages};
    end else if (state == S_DATA && cur.op == CMD_BLOCK) begin
      b_we     = 1'b1;
      wr_entry = r_rd_data;
    end else if (state == S_DATA && cur.op == CMD_UNBLOCK) begin
      r_we     = 1'b1;
      wr_entry = b_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      ready_mem[r_tail] <= wr_entry;
    end
    r_rd_data <= ready_mem[r_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      blocked_mem[b_tail] <= wr_entry;
    end
    b_rd_data <= blocked_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      r_head   <= '0;
      r_tail   <= '0;
      r_fill   <= '0;
      b_head   <= '0;
      b_tail   <= '0;
      b_fill   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(q_pop && idle_done)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur      <= q_cmd;
            o_status <= ST_OK;
            o_pid    <= '0;
            o_pages  <= '0;
            o_found  <= 1'b0;
            o_rc     <= r_fill;
            o_bc     <= b_fill;
            phase    <= 1'b0;
            n        <= '0;
            ptr      <= r_head;
            case (q_cmd.op) inside
              CMD_LOAD: begin
                m_tvalid <= 1'b1;
                if (r_fill == FULL_CNT) begin
                  o_status <= ST_FULL;
                end else begin
                  o_pid   <= q_cmd.pid;
                  o_pages <= q_cmd.pages;
                  r_tail  <= wrap_inc(r_tail);
                  r_fill  <= r_fill + 1'b1;
                  o_rc    <= r_fill + 1'b1;
                end
              end
              CMD_BLOCK: begin
                if (r_fill == '0) begin
                  o_status <= ST_EMPTY;
                  m_tvalid <= 1'b1;
                end else if (b_fill == FULL_CNT) begin
                  o_status <= ST_FULL;
                  m_tvalid <= 1'b1;
                end else begin
                  state <= S_DATA;
                end
              end
              CMD_UNBLOCK: begin
                if (b_fill == '0) begin
                  o_status <= ST_EMPTY;
                  m_tvalid <= 1'b1;
                end else if (r_fill == FULL_CNT) begin
                  o_status <= ST_FULL;
                  m_tvalid <= 1'b1;
                end else begin
                  state <= S_DATA;
                end
              end
              CMD_REMOVE, CMD_PEEK: begin
                if (r_fill == '0) begin
                  o_status <= ST_EMPTY;
                  m_tvalid <= 1'b1;
                end else begin
                  state <= S_DATA;
                end
              end
              CMD_SEARCH: state <= S_SRCH;
              default: m_tvalid <= 1'b1;
            endcase
          end
        end
        S_DATA: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b1;
          case (cur.op)
            CMD_BLOCK: begin
              {o_pid, o_pages} <= r_rd_data;
              r_head <= wrap_inc(r_head);
              r_fill <= r_fill - 1'b1;
              o_rc   <= r_fill - 1'b1;
              b_tail <= wrap_inc(b_tail);
              b_fill <= b_fill + 1'b1;
              o_bc   <= b_fill + 1'b1;
            end
            CMD_UNBLOCK: begin
              {o_pid, o_pages} <= b_rd_data;
              b_head <= wrap_inc(b_head);
              b_fill <= b_fill - 1'b1;
              o_bc   <= b_fill - 1'b1;
              r_tail <= wrap_inc(r_tail);
              r_fill <= r_fill + 1'b1;
              o_rc   <= r_fill + 1'b1;
            end
            CMD_REMOVE: begin
              {o_pid, o_pages} <= r_rd_data;
              r_head <= wrap_inc(r_head);
              r_fill <= r_fill - 1'b1;
              o_rc   <= r_fill - 1'b1;
            end
            default: begin
              {o_pid, o_pages} <= r_rd_data;
            end
          endcase
        end
        S_SRCH: begin
          if (n < lim) begin
            state <= S_CMP;
          end else if (!phase) begin
            phase <= 1'b1;
            ptr   <= b_head;
            n     <= '0;
          end else begin
            o_status <= ST_MISS;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_CMP: begin
          if (cmp_data[ENTRY_W-1:PAGES_W] == cur.pid) begin
            {o_pid, o_pages} <= cmp_data;
            o_found  <= phase;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end else begin
            n     <= n + 1'b1;
            ptr   <= wrap_inc(ptr);
            state <= S_SRCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_fill_bound: assert property (@(posedge clk) disable iff (rst)
    r_fill <= FULL_CNT) else $error("ready fill beyond depth");
  a_blocked_fill_bound: assert property (@(posedge clk) disable iff (rst)
    b_fill <= FULL_CNT) else $error("blocked fill beyond depth");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && q_valid) else $error("command taken while busy");
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && cmp_data[ENTRY_W-1:PAGES_W] != cur.pid) |=> !$rose(m_tvalid))
    else $error("result raised on search miss step");

endmodule

// File: design/ready_blocked_process_queues.sv
// Ready/blocked process queues: load, block, unblock, remove, peek and search
// on two circular queues of QUEUE_DEPTH entries, one result per command.
// A load or a failed command ends in the idle state of the back end, a move, remove
// or peek passes the data state (one registered memory read), and a search takes a
// search and a compare state per entry visited and one more search state per queue;
// the search walk over the memories sets the worst case. Input transfers are queued
// two deep ahead of the back end. Depends on rbpq_pkg, rbpq_front and rbpq_back.
module ready_blocked_process_queues #(
  parameter int QUEUE_DEPTH = rbpq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pid, page_count
  input  logic [2:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_pid, out_pages, ready_count, blocked_count
  output logic [2:0]  m_tuser    // status, found_blocked
);
  import rbpq_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  rbpq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  rbpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
